// ===== src/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// types, kind codes, scan modes and keyword matching for the tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int OFFSET_BITS_DEF   = 24;

  localparam int LINE_W = 20;
  localparam int COL_W  = 16;
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 16;
  localparam int KIND_W = 6;

  localparam logic [KIND_W-1:0] K_EOF    = 6'd0;
  localparam logic [KIND_W-1:0] K_IDENT  = 6'd1;
  localparam logic [KIND_W-1:0] K_INT    = 6'd2;
  localparam logic [KIND_W-1:0] K_DEC    = 6'd3;
  localparam logic [KIND_W-1:0] K_FN     = 6'd4;
  localparam logic [KIND_W-1:0] K_LET    = 6'd5;
  localparam logic [KIND_W-1:0] K_RETURN = 6'd6;
  localparam logic [KIND_W-1:0] K_IF     = 6'd7;
  localparam logic [KIND_W-1:0] K_ELSE   = 6'd8;
  localparam logic [KIND_W-1:0] K_WHILE  = 6'd9;
  localparam logic [KIND_W-1:0] K_FOR    = 6'd10;
  localparam logic [KIND_W-1:0] K_TRUE   = 6'd11;
  localparam logic [KIND_W-1:0] K_FALSE  = 6'd12;
  localparam logic [KIND_W-1:0] K_I32    = 6'd13;
  localparam logic [KIND_W-1:0] K_I64    = 6'd14;
  localparam logic [KIND_W-1:0] K_F32    = 6'd15;
  localparam logic [KIND_W-1:0] K_F64    = 6'd16;
  localparam logic [KIND_W-1:0] K_BOOL   = 6'd17;
  localparam logic [KIND_W-1:0] K_VOID   = 6'd18;
  localparam logic [KIND_W-1:0] K_LPAREN = 6'd19;
  localparam logic [KIND_W-1:0] K_RPAREN = 6'd20;
  localparam logic [KIND_W-1:0] K_LBRACE = 6'd21;
  localparam logic [KIND_W-1:0] K_RBRACE = 6'd22;
  localparam logic [KIND_W-1:0] K_COMMA  = 6'd23;
  localparam logic [KIND_W-1:0] K_COLON  = 6'd24;
  localparam logic [KIND_W-1:0] K_SEMI   = 6'd25;
  localparam logic [KIND_W-1:0] K_PLUS   = 6'd26;
  localparam logic [KIND_W-1:0] K_MINUS  = 6'd27;
  localparam logic [KIND_W-1:0] K_ARROW  = 6'd28;
  localparam logic [KIND_W-1:0] K_STAR   = 6'd29;
  localparam logic [KIND_W-1:0] K_SLASH  = 6'd30;
  localparam logic [KIND_W-1:0] K_MOD    = 6'd31;
  localparam logic [KIND_W-1:0] K_EQ     = 6'd32;
  localparam logic [KIND_W-1:0] K_ASSIGN = 6'd33;
  localparam logic [KIND_W-1:0] K_NE     = 6'd34;
  localparam logic [KIND_W-1:0] K_NOT    = 6'd35;
  localparam logic [KIND_W-1:0] K_LE     = 6'd36;
  localparam logic [KIND_W-1:0] K_LT     = 6'd37;
  localparam logic [KIND_W-1:0] K_GE     = 6'd38;
  localparam logic [KIND_W-1:0] K_GT     = 6'd39;
  localparam logic [KIND_W-1:0] K_AND    = 6'd40;
  localparam logic [KIND_W-1:0] K_OR     = 6'd41;
  localparam logic [KIND_W-1:0] K_ERROR  = 6'd42;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_SLASH   = 4'd3;
  localparam logic [3:0] M_COMMENT = 4'd4;
  localparam logic [3:0] M_MINUS   = 4'd5;
  localparam logic [3:0] M_ASSIGN  = 4'd6;
  localparam logic [3:0] M_BANG    = 4'd7;
  localparam logic [3:0] M_LT      = 4'd8;
  localparam logic [3:0] M_GT      = 4'd9;
  localparam logic [3:0] M_AMP     = 4'd10;
  localparam logic [3:0] M_PIPE    = 4'd11;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
  } token_t;

  // keyword lookup over the first six buffered bytes and the full length
  function automatic logic [KIND_W-1:0] keyword_kind(input logic [47:0] buf6,
                                                     input logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    unique case (len)
      16'd2: begin
        if (buf6[15:0] == 16'h6e66) k = K_FN;
        else if (buf6[15:0] == 16'h6669) k = K_IF;
      end
      16'd3: begin
        if (buf6[23:0] == 24'h74656c) k = K_LET;
        else if (buf6[23:0] == 24'h726f66) k = K_FOR;
        else if (buf6[23:0] == 24'h323369) k = K_I32;
        else if (buf6[23:0] == 24'h343669) k = K_I64;
        else if (buf6[23:0] == 24'h323366) k = K_F32;
        else if (buf6[23:0] == 24'h343666) k = K_F64;
      end
      16'd4: begin
        if (buf6[31:0] == 32'h65736c65) k = K_ELSE;
        else if (buf6[31:0] == 32'h65757274) k = K_TRUE;
        else if (buf6[31:0] == 32'h6c6f6f62) k = K_BOOL;
        else if (buf6[31:0] == 32'h64696f76) k = K_VOID;
      end
      16'd5: begin
        if (buf6[39:0] == 40'h656c696877) k = K_WHILE;
        else if (buf6[39:0] == 40'h65736c6166) k = K_FALSE;
      end
      16'd6: begin
        if (buf6 == 48'h6e7275746572) k = K_RETURN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ===== src/stt_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_scan
// scanner state and combinational token decode, up to two tokens per beat
// ----------------------------------------------------------------------------
module stt_scan #(
  parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF,
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                req_type,
  input  logic [7:0]          source_byte,
  output logic [1:0]          count,
  output stt_pkg::token_t     tok0,
  output stt_pkg::token_t     tok1
);

  localparam int KB_W = 8 * KEYWORD_CHARS;

  logic [3:0]                  scan_mode, scan_mode_next;
  logic [stt_pkg::LINE_W-1:0]  cur_line, cur_line_next, tok_line, tok_line_next;
  logic [stt_pkg::COL_W-1:0]   cur_col, cur_col_next, tok_col, tok_col_next;
  logic [OFFSET_BITS-1:0]      cur_off, cur_off_next, tok_off, tok_off_next;
  logic [stt_pkg::LEN_W-1:0]   tok_cnt, tok_cnt_next;
  logic                        point_seen, point_seen_next;
  logic [KB_W-1:0]             kbuf, kbuf_next;

  logic [7:0] b;
  logic is_dig, is_alp, is_blank, absorbed, have_pend;
  logic [stt_pkg::KIND_W-1:0] pend_kind, one_kind, kw_kind;
  logic [stt_pkg::LEN_W-1:0]  pend_len;
  logic [3:0] start_mode;
  logic [stt_pkg::OFF_W-1:0] tok_off_f, cur_off_f;

  function automatic logic [stt_pkg::OFF_W-1:0] off_field(input logic [OFFSET_BITS-1:0] v);
    logic [stt_pkg::OFF_W-1:0] r;
    if (OFFSET_BITS > stt_pkg::OFF_W) begin
      r = (v > OFFSET_BITS'({stt_pkg::OFF_W{1'b1}})) ? {stt_pkg::OFF_W{1'b1}}
        : stt_pkg::OFF_W'(v);
    end else begin
      r = stt_pkg::OFF_W'(v);
    end
    return r;
  endfunction

  assign b         = source_byte;
  assign is_dig    = (b >= 8'h30) && (b <= 8'h39);
  assign is_alp    = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a))
                     || (b == 8'h5f);
  assign is_blank  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
  assign tok_off_f = off_field(tok_off);
  assign cur_off_f = off_field(cur_off);

  always_comb begin
    logic [47:0] b6;
    b6 = '0;
    for (int i = 0; i < 6; i++) b6[8*i +: 8] = kbuf[8*i +: 8];
    kw_kind = stt_pkg::keyword_kind(b6, tok_cnt);
  end

  // pending token as it stands
  always_comb begin
    have_pend = 1'b1;
    pend_len  = 16'd1;
    pend_kind = stt_pkg::K_ERROR;
    unique case (scan_mode)
      stt_pkg::M_IDENT:  begin pend_kind = kw_kind; pend_len = tok_cnt; end
      stt_pkg::M_NUMBER: begin
        pend_kind = point_seen ? stt_pkg::K_DEC : stt_pkg::K_INT;
        pend_len  = tok_cnt;
      end
      stt_pkg::M_SLASH:  pend_kind = stt_pkg::K_SLASH;
      stt_pkg::M_MINUS:  pend_kind = stt_pkg::K_MINUS;
      stt_pkg::M_ASSIGN: pend_kind = stt_pkg::K_ASSIGN;
      stt_pkg::M_BANG:   pend_kind = stt_pkg::K_NOT;
      stt_pkg::M_LT:     pend_kind = stt_pkg::K_LT;
      stt_pkg::M_GT:     pend_kind = stt_pkg::K_GT;
      stt_pkg::M_AMP:    pend_kind = stt_pkg::K_ERROR;
      stt_pkg::M_PIPE:   pend_kind = stt_pkg::K_ERROR;
      default:           have_pend = 1'b0;
    endcase
  end

  always_comb begin
    start_mode = stt_pkg::M_IDLE;
    one_kind   = stt_pkg::K_ERROR;
    unique case (b)
      8'h28: one_kind = stt_pkg::K_LPAREN;
      8'h29: one_kind = stt_pkg::K_RPAREN;
      8'h7b: one_kind = stt_pkg::K_LBRACE;
      8'h7d: one_kind = stt_pkg::K_RBRACE;
      8'h2c: one_kind = stt_pkg::K_COMMA;
      8'h3a: one_kind = stt_pkg::K_COLON;
      8'h3b: one_kind = stt_pkg::K_SEMI;
      8'h2b: one_kind = stt_pkg::K_PLUS;
      8'h2a: one_kind = stt_pkg::K_STAR;
      8'h25: one_kind = stt_pkg::K_MOD;
      8'h2f: start_mode = stt_pkg::M_SLASH;
      8'h2d: start_mode = stt_pkg::M_MINUS;
      8'h3d: start_mode = stt_pkg::M_ASSIGN;
      8'h21: start_mode = stt_pkg::M_BANG;
      8'h3c: start_mode = stt_pkg::M_LT;
      8'h3e: start_mode = stt_pkg::M_GT;
      8'h26: start_mode = stt_pkg::M_AMP;
      8'h7c: start_mode = stt_pkg::M_PIPE;
      default: begin
        if (is_dig) start_mode = stt_pkg::M_NUMBER;
        else if (is_alp) start_mode = stt_pkg::M_IDENT;
      end
    endcase
  end

  always_comb begin
    stt_pkg::token_t t0, t1;
    logic [1:0] n;
    logic two;
    scan_mode_next  = scan_mode;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    cur_off_next    = cur_off;
    tok_line_next   = tok_line;
    tok_col_next    = tok_col;
    tok_off_next    = tok_off;
    tok_cnt_next    = tok_cnt;
    point_seen_next = point_seen;
    kbuf_next       = kbuf;
    absorbed        = 1'b0;
    two             = 1'b0;
    n  = 2'd0;
    t0 = '{kind: pend_kind, line: tok_line, column: tok_col, offset: tok_off_f,
           length: pend_len};
    t1 = '{kind: stt_pkg::K_EOF, line: cur_line, column: cur_col, offset: cur_off_f,
           length: '0};
    if (req_type) begin
      if (have_pend) begin
        n = 2'd2;
      end else begin
        n  = 2'd1;
        t0 = t1;
      end
      scan_mode_next  = stt_pkg::M_IDLE;
      cur_line_next   = 20'd1;
      cur_col_next    = 16'd1;
      cur_off_next    = '0;
      tok_line_next   = 20'd1;
      tok_col_next    = 16'd1;
      tok_off_next    = '0;
      tok_cnt_next    = '0;
      point_seen_next = 1'b0;
      kbuf_next       = '0;
    end else begin
      unique case (scan_mode) inside
        stt_pkg::M_IDENT: begin
          if (is_alp || is_dig) begin
            absorbed = 1'b1;
            for (int i = 0; i < KEYWORD_CHARS; i++)
              if (tok_cnt == 16'(i)) kbuf_next[8*i +: 8] = kbuf[8*i +: 8] | b;
          end
        end
        stt_pkg::M_NUMBER: begin
          if (is_dig || (b == 8'h2e && !point_seen)) begin
            absorbed = 1'b1;
            if (b == 8'h2e) point_seen_next = 1'b1;
          end
        end
        stt_pkg::M_SLASH:
          if (b == 8'h2f) begin absorbed = 1'b1; scan_mode_next = stt_pkg::M_COMMENT; end
        stt_pkg::M_COMMENT: begin
          if (b != 8'h0a) absorbed = 1'b1;
          else scan_mode_next = stt_pkg::M_IDLE;
        end
        stt_pkg::M_MINUS:  two = (b == 8'h3e);
        stt_pkg::M_ASSIGN, stt_pkg::M_BANG, stt_pkg::M_LT, stt_pkg::M_GT:
          two = (b == 8'h3d);
        stt_pkg::M_AMP:    two = (b == 8'h26);
        stt_pkg::M_PIPE:   two = (b == 8'h7c);
        default: ;
      endcase
      if ((scan_mode == stt_pkg::M_IDENT || scan_mode == stt_pkg::M_NUMBER) && absorbed
          && tok_cnt != 16'hffff)
        tok_cnt_next = tok_cnt + 16'd1;
      if (two) begin
        absorbed       = 1'b1;
        n              = 2'd1;
        t0.length      = 16'd2;
        scan_mode_next = stt_pkg::M_IDLE;
        unique case (scan_mode)
          stt_pkg::M_MINUS:  t0.kind = stt_pkg::K_ARROW;
          stt_pkg::M_ASSIGN: t0.kind = stt_pkg::K_EQ;
          stt_pkg::M_BANG:   t0.kind = stt_pkg::K_NE;
          stt_pkg::M_LT:     t0.kind = stt_pkg::K_LE;
          stt_pkg::M_GT:     t0.kind = stt_pkg::K_GE;
          stt_pkg::M_AMP:    t0.kind = stt_pkg::K_AND;
          default:           t0.kind = stt_pkg::K_OR;
        endcase
      end
      if (!absorbed) begin
        if (have_pend) begin
          n              = 2'd1;
          scan_mode_next = stt_pkg::M_IDLE;
        end
        if (!is_blank) begin
          tok_line_next   = cur_line;
          tok_col_next    = cur_col;
          tok_off_next    = cur_off;
          tok_cnt_next    = 16'd1;
          point_seen_next = 1'b0;
          kbuf_next       = '0;
          if (start_mode == stt_pkg::M_IDENT) kbuf_next[7:0] = b;
          scan_mode_next = start_mode;
          if (start_mode == stt_pkg::M_IDLE) begin
            t1 = '{kind: one_kind, line: cur_line, column: cur_col, offset: cur_off_f,
                   length: 16'd1};
            if (have_pend) n = 2'd2;
            else begin n = 2'd1; t0 = t1; end
          end
        end
      end
      if (b == 8'h0a) begin
        if (cur_line != {stt_pkg::LINE_W{1'b1}}) cur_line_next = cur_line + 20'd1;
        cur_col_next = 16'd1;
      end else if (cur_col != {stt_pkg::COL_W{1'b1}}) begin
        cur_col_next = cur_col + 16'd1;
      end
      if (cur_off != {OFFSET_BITS{1'b1}}) cur_off_next = cur_off + 1'b1;
    end
    count = n;
    tok0  = t0;
    tok1  = t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode  <= stt_pkg::M_IDLE;
      cur_line   <= 20'd1;
      cur_col    <= 16'd1;
      cur_off    <= '0;
      tok_line   <= 20'd1;
      tok_col    <= 16'd1;
      tok_off    <= '0;
      tok_cnt    <= '0;
      point_seen <= 1'b0;
      kbuf       <= '0;
    end else if (step) begin
      scan_mode  <= scan_mode_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      cur_off    <= cur_off_next;
      tok_line   <= tok_line_next;
      tok_col    <= tok_col_next;
      tok_off    <= tok_off_next;
      tok_cnt    <= tok_cnt_next;
      point_seen <= point_seen_next;
      kbuf       <= kbuf_next;
    end
  end

endmodule

// ===== src/stt_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_outq
// four-entry token queue between decode and the result channel
// ----------------------------------------------------------------------------
module stt_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_n,
  input  stt_pkg::token_t push0,
  input  stt_pkg::token_t push1,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output stt_pkg::token_t out_tok,
  output logic            out_last
);

  stt_pkg::token_t q [4];
  logic            ql [4];
  logic [1:0] rd, wr;
  logic [2:0] fill;
  logic pop;

  assign out_valid = (fill != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_tok   = q[rd];
  assign out_last  = ql[rd];
  // room for two more after any pop this cycle is not counted
  assign room      = (fill <= 3'd2);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wr]  <= push0;
      ql[wr] <= (push_n == 2'd1);
    end
    if (push_n == 2'd2) begin
      q[wr + 2'd1]  <= push1;
      ql[wr + 2'd1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd   <= '0;
      wr   <= '0;
      fill <= '0;
    end else begin
      wr   <= wr + push_n;
      rd   <= rd + {1'b0, pop};
      fill <= fill + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

// ===== src/source_text_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// streaming lexer: source bytes in, tokens with position and length out
// ----------------------------------------------------------------------------
// channel  | handshake          | beat
// in       | in_valid/in_stall  | req_type, source_byte
// out      | out_valid/out_stall| token_kind .. token_length, last_of_run
//
// one input beat per cycle while in_stall is low; each beat is decoded in the cycle it is taken
// and its zero to two tokens are registered into a four-entry queue
// rst (synchronous) empties the queue and returns the scanner to line 1
// in_stall rises while the queue holds more than two tokens
module source_text_tokenizer_unit #(
  parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF,
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [7:0]                   source_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stt_pkg::KIND_W-1:0]   token_kind,
  output logic [stt_pkg::LINE_W-1:0]   start_line,
  output logic [stt_pkg::COL_W-1:0]    start_column,
  output logic [stt_pkg::OFF_W-1:0]    start_offset,
  output logic [stt_pkg::LEN_W-1:0]    token_length,
  output logic                         last_of_run
);

  logic step, room;
  logic [1:0] n;
  stt_pkg::token_t t0, t1, ot;

  assign in_stall = !room;
  assign step     = in_valid && room;

  stt_scan #(.KEYWORD_CHARS(KEYWORD_CHARS), .OFFSET_BITS(OFFSET_BITS)) u_scan (
    .clk, .rst, .step, .req_type, .source_byte,
    .count(n), .tok0(t0), .tok1(t1)
  );

  stt_outq u_q (
    .clk, .rst,
    .push_n(step ? n : 2'd0), .push0(t0), .push1(t1),
    .room, .out_valid, .out_stall, .out_tok(ot), .out_last(last_of_run)
  );

  assign token_kind   = ot.kind;
  assign start_line   = ot.line;
  assign start_column = ot.column;
  assign start_offset = ot.offset;
  assign token_length = ot.length;

endmodule

// ===== src/stt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_checker
// port-level checks on the tokenizer
// ----------------------------------------------------------------------------
module stt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [stt_pkg::KIND_W-1:0] token_kind,
  input logic [stt_pkg::LINE_W-1:0] start_line,
  input logic [stt_pkg::COL_W-1:0]  start_column,
  input logic [stt_pkg::LEN_W-1:0]  token_length,
  input logic                       last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind))
    else $error("stalled beat changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input beat withdrawn");

  a_eof_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == stt_pkg::K_EOF |-> token_length == 16'd0 && last_of_run)
    else $error("eof beat malformed");

  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> start_line != 20'd0 && start_column != 16'd0)
    else $error("position zero");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= stt_pkg::K_ERROR)
    else $error("kind out of range");

endmodule

bind source_text_tokenizer_unit stt_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .token_kind, .start_line, .start_column, .token_length, .last_of_run
);
